FILE: src/eed_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ElGamal encrypt/decrypt block.
// No dependencies; imported by every other module in src.
package eed_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;

  localparam logic FUNC_ENCRYPT = 1'b0;
  localparam logic FUNC_DECRYPT = 1'b1;

  // configuration register indexes
  localparam logic [7:0] REG_MODULUS     = 8'd0;
  localparam logic [7:0] REG_GENERATOR   = 8'd1;
  localparam logic [7:0] REG_PUBLIC_KEY  = 8'd2;
  localparam logic [7:0] REG_PRIVATE_KEY = 8'd3;

  // which operands feed the modular multiplier and where the product goes
  typedef enum logic [1:0] {
    MS_SQRED,   // base * 1: reduce the base into sq
    MS_ACC,     // acc * sq -> acc
    MS_SQ,      // sq * sq  -> sq
    MS_FIN      // message (or c2) * power -> result
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POW_LOAD,
    ST_RED_GO,
    ST_RED_WAIT,
    ST_BIT,
    ST_ACC_WAIT,
    ST_SQ_WAIT,
    ST_POW_END,
    ST_FIN_GO,
    ST_FIN_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     pow_load;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     ex_shift;
    logic     pow_store;
    logic     phase;      // 0: first power, 1: second power of an encrypt
  } cmd_t;

  typedef struct packed {
    logic func;
    logic base_zero;
    logic ex_zero;
    logic ex_bit;
    logic mul_done;
  } status_t;

endpackage

FILE: src/eed_modmul.sv
`timescale 1ns / 1ps
// Bit-serial interleaved modular multiplier, one bit of a per cycle.
// Depends on eed_pkg.
module eed_modmul (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  eed_pkg::word_t a,
  input  eed_pkg::word_t b,      // must not exceed p
  input  eed_pkg::word_t p,
  output logic           busy,
  output logic           done,
  output eed_pkg::word_t result
);
  import eed_pkg::*;

  word_t               a_q;
  word_t               b_q;
  word_t               r;
  logic [CNT_BITS-1:0] cnt;

  logic [WORD_BITS:0] dbl;
  logic [WORD_BITS:0] dbl_red;
  logic [WORD_BITS:0] sum;
  logic [WORD_BITS:0] sum_red;

  // one step: r = (2r mod p + a_bit * b) mod p, both values stay below 2p
  always_comb begin
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= {1'b0, p}) ? dbl - {1'b0, p} : dbl;
    sum     = dbl_red + (a_q[WORD_BITS-1] ? {1'b0, b_q} : '0);
    sum_red = (sum >= {1'b0, p}) ? sum - {1'b0, p} : sum;
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(WORD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand and remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
      r   <= '0;
    end else if (busy) begin
      a_q <= {a_q[WORD_BITS-2:0], 1'b0};
      r   <= sum_red[WORD_BITS-1:0];
    end
  end

  // a zero modulus makes every product zero
  assign result = (p == '0) ? '0 : r;

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("multiplier did not go busy after start");
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("multiplier done while still busy");
  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    (done && p != '0) |-> (result < p))
    else $error("multiplier result not reduced");

endmodule

FILE: src/eed_datapath.sv
`timescale 1ns / 1ps
// Operand registers, power accumulator and result registers of the block.
// Depends on eed_pkg and eed_modmul.
module eed_datapath (
  input  logic              clk,
  input  logic              rst,
  input  eed_pkg::cmd_t     cmd,
  output eed_pkg::status_t  status,
  input  logic              in_func,
  input  eed_pkg::word_t    in_message,
  input  eed_pkg::word_t    in_ephemeral_key,
  input  eed_pkg::word_t    in_cipher_first,
  input  eed_pkg::word_t    in_cipher_second,
  input  eed_pkg::word_t    modulus,
  input  eed_pkg::word_t    generator,
  input  eed_pkg::word_t    public_key,
  input  eed_pkg::word_t    private_key,
  output eed_pkg::word_t    out_first,
  output eed_pkg::word_t    out_second,
  output logic              message_too_large
);
  import eed_pkg::*;

  logic     func_q;
  word_t    msg_q;
  word_t    k_q;
  word_t    c1in_q;
  word_t    c2in_q;
  word_t    base;
  word_t    ex;
  word_t    acc;
  word_t    sq;
  word_t    pow_q;
  word_t    c1_q;
  logic     base_zero;
  logic     ex_zero;
  mul_sel_t dest;

  word_t one_red;
  word_t base_next;
  word_t ex_next;
  word_t mul_a;
  word_t mul_b;
  word_t pow_val;
  logic  mul_busy;
  logic  mul_done;
  word_t mul_res;

  assign one_red = (modulus == word_t'(1)) ? '0 : word_t'(1);

  // base and exponent of the power about to start
  always_comb begin
    if (cmd.phase) begin
      base_next = public_key;
      ex_next   = k_q;
    end else if (func_q == FUNC_DECRYPT) begin
      base_next = c1in_q;
      ex_next   = modulus - word_t'(1) - private_key;
    end else begin
      base_next = generator;
      ex_next   = k_q;
    end
  end

  // multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MS_SQRED: begin
        mul_a = base;
        mul_b = one_red;
      end
      MS_ACC: begin
        mul_a = acc;
        mul_b = sq;
      end
      MS_SQ: begin
        mul_a = sq;
        mul_b = sq;
      end
      MS_FIN: begin
        mul_a = (func_q == FUNC_DECRYPT) ? c2in_q : msg_q;
        mul_b = pow_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  eed_modmul u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_go),
    .a      (mul_a),
    .b      (mul_b),
    .p      (modulus),
    .busy   (mul_busy),
    .done   (mul_done),
    .result (mul_res)
  );

  // zero base gives 0, else zero exponent gives 1
  assign pow_val = base_zero ? '0 : (ex_zero ? word_t'(1) : acc);

  // destination of the running product
  always_ff @(posedge clk) begin
    if (rst) begin
      dest <= MS_SQRED;
    end else if (cmd.mul_go) begin
      dest <= cmd.mul_sel;
    end
  end

  // request capture, power registers and results
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= in_func;
      msg_q  <= in_message;
      k_q    <= in_ephemeral_key;
      c1in_q <= in_cipher_first;
      c2in_q <= in_cipher_second;
    end
    if (cmd.pow_load) begin
      base      <= base_next;
      ex        <= ex_next;
      acc       <= one_red;
      base_zero <= (base_next == '0);
      ex_zero   <= (ex_next == '0);
    end
    if (cmd.ex_shift) begin
      ex <= {1'b0, ex[WORD_BITS-1:1]};
    end
    if (cmd.pow_store) begin
      if (!cmd.phase && func_q == FUNC_ENCRYPT) begin
        c1_q <= pow_val;
      end else begin
        pow_q <= pow_val;
      end
    end
    if (mul_done) begin
      case (dest)
        MS_SQRED: sq  <= mul_res;
        MS_ACC:   acc <= mul_res;
        MS_SQ:    sq  <= mul_res;
        MS_FIN: begin
          if (func_q == FUNC_DECRYPT) begin
            out_first         <= mul_res;
            out_second        <= '0;
            message_too_large <= 1'b0;
          end else begin
            out_first         <= c1_q;
            out_second        <= mul_res;
            message_too_large <= (msg_q >= modulus);
          end
        end
        default: sq <= sq;
      endcase
    end
  end

  assign status = '{
    func:      func_q,
    base_zero: base_zero,
    ex_zero:   ex_zero,
    ex_bit:    ex[0],
    mul_done:  mul_done & ~mul_busy
  };

endmodule

FILE: src/eed_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: square-and-multiply over the exponent bits, then the final product.
// Depends on eed_pkg.
module eed_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  eed_pkg::status_t status,
  output eed_pkg::cmd_t    cmd
);
  import eed_pkg::*;

  state_t              state;
  state_t              state_next;
  logic                phase;
  logic                phase_next;
  logic [CNT_BITS-1:0] bitcnt;
  logic [CNT_BITS-1:0] bitcnt_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      phase  <= 1'b0;
      bitcnt <= '0;
    end else begin
      state  <= state_next;
      phase  <= phase_next;
      bitcnt <= bitcnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    phase_next  = phase;
    bitcnt_next = bitcnt;
    s_tready    = 1'b0;
    m_tvalid    = 1'b0;
    cmd         = '{capture: 1'b0, pow_load: 1'b0, mul_go: 1'b0, mul_sel: MS_SQRED,
                    ex_shift: 1'b0, pow_store: 1'b0, phase: phase};
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          phase_next  = 1'b0;
          state_next  = ST_POW_LOAD;
        end
      end
      ST_POW_LOAD: begin
        cmd.pow_load = 1'b1;
        bitcnt_next  = '0;
        state_next   = ST_RED_GO;
      end
      ST_RED_GO: begin
        if (status.base_zero || status.ex_zero) begin
          state_next = ST_POW_END;
        end else begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = MS_SQRED;
          state_next  = ST_RED_WAIT;
        end
      end
      ST_RED_WAIT: begin
        if (status.mul_done) begin
          state_next = ST_BIT;
        end
      end
      ST_BIT: begin
        cmd.mul_go = 1'b1;
        if (status.ex_bit) begin
          cmd.mul_sel = MS_ACC;
          state_next  = ST_ACC_WAIT;
        end else begin
          cmd.mul_sel = MS_SQ;
          state_next  = ST_SQ_WAIT;
        end
      end
      ST_ACC_WAIT: begin
        if (status.mul_done) begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = MS_SQ;
          state_next  = ST_SQ_WAIT;
        end
      end
      ST_SQ_WAIT: begin
        if (status.mul_done) begin
          cmd.ex_shift = 1'b1;
          if (bitcnt == CNT_BITS'(WORD_BITS - 1)) begin
            state_next = ST_POW_END;
          end else begin
            bitcnt_next = bitcnt + 1'b1;
            state_next  = ST_BIT;
          end
        end
      end
      ST_POW_END: begin
        cmd.pow_store = 1'b1;
        if (status.func == FUNC_ENCRYPT && !phase) begin
          phase_next = 1'b1;
          state_next = ST_POW_LOAD;
        end else begin
          state_next = ST_FIN_GO;
        end
      end
      ST_FIN_GO: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MS_FIN;
        state_next  = ST_FIN_WAIT;
      end
      ST_FIN_WAIT: begin
        if (status.mul_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: src/elgamal_encrypt_decrypt.sv
`timescale 1ns / 1ps
// ElGamal encrypt/decrypt over a 32-bit modulus, one request at a time. An encrypt
// computes two modular powers and a decrypt one, then both compute one final product;
// each modular product runs 32 bit-serial steps between start and done, and each
// exponent bit costs one squaring plus one multiply when the bit is set. A zero base
// or zero exponent skips its power. Registers are written over cfg_*.
// Depends on eed_pkg, eed_ctrl, eed_datapath and eed_modmul.
module elgamal_encrypt_decrypt (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // message, ephemeral_key, cipher_first, cipher_second
  input  logic [0:0]   s_tuser,   // func
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // out_first, out_second
  output logic [0:0]   m_tuser,   // message_too_large
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import eed_pkg::*;

  word_t   modulus;
  word_t   generator;
  word_t   public_key;
  word_t   private_key;
  cmd_t    cmd;
  status_t status;
  word_t   out_first;
  word_t   out_second;
  logic    message_too_large;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= word_t'(3);
      generator   <= word_t'(2);
      public_key  <= word_t'(1);
      private_key <= word_t'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODULUS:     modulus     <= cfg_data;
        REG_GENERATOR:   generator   <= cfg_data;
        REG_PUBLIC_KEY:  public_key  <= cfg_data;
        REG_PRIVATE_KEY: private_key <= cfg_data;
        default:         modulus     <= modulus;
      endcase
    end
  end

  eed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  eed_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .in_func           (s_tuser[0]),
    .in_message        (s_tdata[31:0]),
    .in_ephemeral_key  (s_tdata[63:32]),
    .in_cipher_first   (s_tdata[95:64]),
    .in_cipher_second  (s_tdata[127:96]),
    .modulus           (modulus),
    .generator         (generator),
    .public_key        (public_key),
    .private_key       (private_key),
    .out_first         (out_first),
    .out_second        (out_second),
    .message_too_large (message_too_large)
  );

  assign m_tdata = {out_second, out_first};
  assign m_tuser = message_too_large;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while another is in flight");
  a_result_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input open while a result is pending");
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while waiting");

endmodule

FILE: sim/elgamal_encrypt_decrypt_checker.sv
`timescale 1ns / 1ps
// Result checker for the ElGamal encrypt/decrypt block: watches the request, result
// and register-write channels, predicts each result and compares. Depends on eed_pkg.
module elgamal_encrypt_decrypt_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,
  input  logic [0:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,
  input  logic [0:0]   m_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           pending
);
  import eed_pkg::*;

  typedef struct packed {
    word_t first;
    word_t second;
    logic  too_large;
  } answer_t;

  word_t   p_mod, g_gen, e_pub, d_priv;
  answer_t answers[$];

  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] p);
    if (p == 0) return 0;
    return ((a % p) * (b % p)) % p;
  endfunction

  function automatic word_t powmod(word_t base, word_t ex, word_t p);
    logic [63:0] acc, sq;
    if (base == 0) return 0;
    if (ex == 0) return 1;
    acc = (p == 0) ? 0 : 64'd1 % p;
    sq  = (p == 0) ? 0 : base % p;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (ex[i]) acc = mulmod(acc, sq, p);
      sq = mulmod(sq, sq, p);
    end
    return acc[31:0];
  endfunction

  function automatic answer_t predict_cipher(logic func, logic [127:0] d);
    answer_t r;
    word_t   ex;
    logic [63:0] t;
    if (func == FUNC_ENCRYPT) begin
      r.first     = powmod(g_gen, d[63:32], p_mod);
      t           = mulmod(powmod(e_pub, d[63:32], p_mod), d[31:0], p_mod);
      r.second    = t[31:0];
      r.too_large = ({32'd0, d[31:0]} >= {32'd0, p_mod});
    end else begin
      ex          = p_mod - 32'd1 - d_priv;
      t           = mulmod(powmod(d[95:64], ex, p_mod), d[127:96], p_mod);
      r.first     = t[31:0];
      r.second    = '0;
      r.too_large = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    answer_t exp_r;
    if (rst) begin
      p_mod <= 32'd3; g_gen <= 32'd2; e_pub <= 32'd1; d_priv <= 32'd1;
      fail_count <= 0;
      pending <= 0;
      answers.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODULUS:     p_mod  <= cfg_data;
          REG_GENERATOR:   g_gen  <= cfg_data;
          REG_PUBLIC_KEY:  e_pub  <= cfg_data;
          REG_PRIVATE_KEY: d_priv <= cfg_data;
          default: ;
        endcase
      end
      // requests
      if (s_tvalid && s_tready) answers.push_back(predict_cipher(s_tuser[0], s_tdata));
      // results
      if (m_tvalid && m_tready) begin
        if (answers.size() == 0) begin
          $display("%0t: unexpected result %h/%b", $time, m_tdata, m_tuser);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = answers.pop_front();
          if (m_tdata != {exp_r.second, exp_r.first} || m_tuser[0] != exp_r.too_large) begin
            $display("%0t: expected %h %h %b, got %h %h %b", $time, exp_r.first,
                     exp_r.second, exp_r.too_large, m_tdata[31:0], m_tdata[63:32], m_tuser[0]);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= answers.size();
    end
  end

endmodule

FILE: sim/elgamal_encrypt_decrypt_test.sv
`timescale 1ns / 1ps
// Testbench top for elgamal_encrypt_decrypt: clock, reset, requests, register writes
// and verdict. Depends on eed_pkg, the block and elgamal_encrypt_decrypt_checker.
module elgamal_encrypt_decrypt_test;
  import eed_pkg::*;

  logic         clk, rst;
  logic         s_tvalid, s_tready, m_tvalid, m_tready, cfg_valid, cfg_ready;
  logic [127:0] s_tdata;   // message, ephemeral_key, cipher_first, cipher_second
  logic [0:0]   s_tuser;   // func
  logic [63:0]  m_tdata;   // out_first, out_second
  logic [0:0]   m_tuser;   // message_too_large
  logic [7:0]   cfg_index;
  logic [31:0]  cfg_data;
  int           fail_count, pending;
  bit           calm;      // no stalls near the end

  elgamal_encrypt_decrypt u_top (.*);
  elgamal_encrypt_decrypt_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // limit: ~140 requests at worst-case length plus stalls, several times over
  initial begin
    #100ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver stalls in bursts
  initial begin
    m_tready = 0;
    forever begin
      @(posedge clk);
      if (calm || $urandom_range(0, 3) != 0) m_tready <= 1;
      else begin
        m_tready <= 0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        m_tready <= 1;
      end
    end
  end

  // valid drops after each write, so each write makes a single update
  task automatic write_reg(logic [7:0] idx, word_t val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_cipher(logic func, word_t m, word_t k, word_t c1, word_t c2);
    if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 17)) @(posedge clk);
    s_tvalid <= 1; s_tuser <= func; s_tdata <= {c2, c1, k, m};
    do @(posedge clk); while (!s_tready);
    s_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic set_keys(word_t p, word_t g, word_t e, word_t d);
    write_reg(REG_MODULUS, p); write_reg(REG_GENERATOR, g);
    write_reg(REG_PUBLIC_KEY, e); write_reg(REG_PRIVATE_KEY, d);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      send_cipher(1'($urandom_range(0, 1)), pick_word(), pick_word(), pick_word(),
                  pick_word());
  endtask

  initial begin
    rst = 1; calm = 0;
    s_tvalid = 0; s_tdata = '0; s_tuser = '0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset keys, zero base/exponent, message above modulus
    send_cipher(FUNC_ENCRYPT, 32'd1, 32'd5, 0, 0);
    send_cipher(FUNC_ENCRYPT, 32'd7, 32'd0, 0, 0);
    send_cipher(FUNC_DECRYPT, 0, 0, 32'd0, 32'd2);
    send_cipher(FUNC_DECRYPT, 0, 0, 32'd3, 32'hFFFF_FFFF);
    drain;
    // largest 32-bit prime, private key wrapping the exponent
    set_keys(32'hFFFF_FFFB, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cipher(FUNC_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send_cipher(FUNC_ENCRYPT, 32'hFFFF_FFFA, 32'd1, 0, 0);
    send_cipher(FUNC_DECRYPT, 0, 0, 32'hFFFF_FFFB, 32'd9);
    send_cipher(FUNC_DECRYPT, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain;
    // degenerate moduli zero, one, two; generator zero
    set_keys(32'd0, 32'd0, 32'd3, 32'd1);
    send_cipher(FUNC_ENCRYPT, 32'd0, 32'd4, 0, 0);
    send_cipher(FUNC_DECRYPT, 0, 0, 32'd6, 32'd7);
    drain;
    write_reg(REG_MODULUS, 32'd1);
    send_cipher(FUNC_ENCRYPT, 32'd3, 32'd0, 0, 0);
    send_cipher(FUNC_DECRYPT, 0, 0, 32'd5, 32'd5);
    drain;
    write_reg(REG_MODULUS, 32'd2);
    write_reg(8'd9, 32'd1234); // unmapped index
    send_cipher(FUNC_ENCRYPT, 32'd1, 32'd3, 0, 0);
    send_cipher(FUNC_DECRYPT, 0, 0, 32'd4, 32'd1);
    drain;

    // random phases over several key sets
    set_keys(32'd2147483647, 32'd7, 32'd16807, 32'd1000);
    random_phase(40);
    drain;
    set_keys(32'd65521, 32'd17, $urandom, 32'hFFFF_FFFF);
    random_phase(30);
    drain;
    set_keys($urandom, $urandom, $urandom, $urandom);
    random_phase(30);
    drain;
    calm = 1;
    set_keys(32'hFFFF_FFFB, $urandom, $urandom, $urandom_range(1, 100));
    random_phase(25);
    drain;

    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
src/eed_pkg.sv
src/eed_modmul.sv
src/eed_datapath.sv
src/eed_ctrl.sv
src/elgamal_encrypt_decrypt.sv
sim/elgamal_encrypt_decrypt_checker.sv
sim/elgamal_encrypt_decrypt_test.sv
